/* src/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/trbf_pkg.sv */
// Shared types, constants and the coefficient rounding function of the
// tilt/roll filter. No dependencies.
`default_nettype none

package trbf_pkg;

  // Field widths
  localparam int AccelW   = 16;
  localparam int InDataW  = 3 * AccelW;
  localparam int RollW    = 24;
  localparam int WordW    = 48;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 2;

  // Pipeline depth: input, scale products, scaled roll, b*x, delay line, output
  localparam int NumStages = 6;

  // Roll scaling: x = round(|sel| * 450 * 2^24 / 49) computed as
  // (|sel| * ScaleK + half) >> ScaleShift, exact for every 16-bit sample.
  localparam int AbsW       = 16;
  localparam int ScaleShift = 21;
  localparam int ScaleKW    = 49;
  localparam int ScaleLoW   = 24;
  localparam int ScaleHiW   = ScaleKW - ScaleLoW;
  localparam logic [ScaleKW-1:0] ScaleK =
    ScaleKW'((64'd450 * (64'd1 << (24 + ScaleShift)) + 64'd24) / 64'd49);
  localparam int PpHiW  = AbsW + ScaleHiW;
  localparam int PpLoW  = AbsW + ScaleLoW;
  localparam int MagSumW = PpHiW + ScaleLoW;
  localparam int XMagW  = 43;

  // Filter coefficients, signed Q1.30
  localparam int CoefW     = 32;
  localparam int CoefFracW = 30;
  localparam logic signed [CoefW-1:0] CoefB  = 32'sd166589;
  localparam logic signed [CoefW-1:0] CoefA0 = -32'sd1036248020;
  localparam logic signed [CoefW-1:0] CoefA1 = 32'sd2109323487;

  localparam int ProdW = WordW + CoefW;
  localparam int AccW  = ProdW - CoefFracW;
  localparam int SumW  = WordW + 3;
  localparam int OutShift = 24;
  localparam logic signed [ProdW-1:0] ProdHalf = ProdW'(1) <<< (CoefFracW - 1);

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAxisSelect = 2'd0,
    CfgInvertRoll = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [NumStages-1:0] load;
    logic                 in_ready;
    logic                 out_valid;
  } trbf_ctrl_t;

  // round(w * c / 2^30), half toward +inf
  function automatic logic signed [AccW-1:0] coef_round(
    input logic signed [WordW-1:0] w,
    input logic signed [CoefW-1:0] c
  );
    logic signed [ProdW-1:0] p;
    p = ProdW'(w) * ProdW'(c) + ProdHalf;
    return p[ProdW-1:CoefFracW];
  endfunction

endpackage

`default_nettype wire

/* src/tilt_roll_butterworth_filter.sv */
// An accepted input beat passes the input, scale-product, scaled-roll, b*x, delay-line and output registers in turn.
// Throughput: one sample per clock while the output is not stalled; the delay-line update is combinational.
// Backpressure drains stage by stage, so empty stages keep taking input beats.
// Reset (rst_ni low, asynchronous): pipeline empties, delay line and configuration clear.
// Configuration writes are taken in any cycle; cfg_ready_o is always high.
// Depends on trbf_pkg, trbf_ctrl, trbf_scale and trbf_iir.
`default_nettype none

module tilt_roll_butterworth_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: accel_x[15:0], accel_y[15:0], accel_z[15:0]
  input  logic [trbf_pkg::InDataW-1:0]  s_axis_tdata,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: roll_angle[23:0]
  output logic [trbf_pkg::RollW-1:0]    m_axis_tdata,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trbf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trbf_pkg::CfgDataW-1:0] cfg_data_i
);
  import trbf_pkg::*;

  trbf_ctrl_t ctrl;
  word_t      x_scaled;
  logic [1:0] axis_sel_d, axis_sel_q;
  logic       invert_d, invert_q;

  // Configuration registers: writes beyond the register list are dropped.
  always_comb begin
    axis_sel_d = axis_sel_q;
    invert_d   = invert_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgAxisSelect: axis_sel_d = cfg_data_i[1:0];
        CfgInvertRoll: invert_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_sel_q <= '0;
      invert_q   <= 1'b0;
    end else begin
      axis_sel_q <= axis_sel_d;
      invert_q   <= invert_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Valid flags and load enables for all six stages
  trbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  // Stages 0 to 2: capture the beat, pick and sign the axis, scale to degrees
  trbf_scale u_scale (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .in_data_i  (s_axis_tdata),
    .axis_sel_i (axis_sel_q),
    .invert_i   (invert_q),
    .x_o        (x_scaled)
  );

  // Stages 3 to 5: b*x, delay line advance, rounded and saturated output
  trbf_iir u_iir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .x_i    (x_scaled),
    .roll_o (m_axis_tdata)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tvalid = ctrl.out_valid;

endmodule

`default_nettype wire

/* src/trbf_scale.sv */
// Front end: input register, axis select and negate, and scaling of the
// selected axis to a Q15.32 roll angle. Depends on trbf_pkg.
`default_nettype none

module trbf_scale (
  input  logic                         clk_i,
  input  trbf_pkg::trbf_ctrl_t         ctrl_i,
  input  logic [trbf_pkg::InDataW-1:0] in_data_i,
  input  logic [1:0]                   axis_sel_i,
  input  logic                         invert_i,
  output trbf_pkg::word_t              x_o
);
  import trbf_pkg::*;

  logic [InDataW-1:0]  data_q;
  logic signed [AbsW:0] sel;
  logic signed [AbsW:0] sel_n;
  logic [AbsW:0]       abs_v;
  logic [PpHiW-1:0]    pp_hi_d, pp_hi_q;
  logic [PpLoW-1:0]    pp_lo_d, pp_lo_q;
  logic                neg_d, neg_q;
  logic [MagSumW-1:0]  mag_sum;
  logic [XMagW-1:0]    x_mag;
  word_t               x_d, x_q;

  always_comb begin
    case (axis_sel_i)
      AxisX:   sel = (AbsW+1)'(signed'(data_q[AccelW-1:0]));
      AxisY:   sel = (AbsW+1)'(signed'(data_q[2*AccelW-1:AccelW]));
      AxisZ:   sel = (AbsW+1)'(signed'(data_q[3*AccelW-1:2*AccelW]));
      default: sel = '0;
    endcase
    sel_n   = invert_i ? -sel : sel;
    neg_d   = sel_n[AbsW];
    abs_v   = neg_d ? unsigned'(-sel_n) : unsigned'(sel_n);
    pp_hi_d = PpHiW'(abs_v[AbsW-1:0]) * PpHiW'(ScaleK[ScaleKW-1:ScaleLoW]);
    pp_lo_d = PpLoW'(abs_v[AbsW-1:0]) * PpLoW'(ScaleK[ScaleLoW-1:0]);
  end

  always_comb begin
    mag_sum = {pp_hi_q, {ScaleLoW{1'b0}}} + MagSumW'(pp_lo_q)
            + (MagSumW'(1) << (ScaleShift - 1));
    x_mag   = mag_sum[ScaleShift+XMagW-1:ScaleShift];
    x_d     = neg_q ? -signed'(WordW'(x_mag)) : signed'(WordW'(x_mag));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      data_q <= in_data_i;
    end
    if (ctrl_i.load[1]) begin
      pp_hi_q <= pp_hi_d;
      pp_lo_q <= pp_lo_d;
      neg_q   <= neg_d;
    end
    if (ctrl_i.load[2]) begin
      x_q <= x_d;
    end
  end

  assign x_o = x_q;

endmodule

`default_nettype wire

/* src/trbf_iir.sv */
// Second-order low-pass section: b*x product stage, three-word delay line
// and saturated Q15.8 output register. Depends on trbf_pkg.
`default_nettype none

module trbf_iir (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  trbf_pkg::trbf_ctrl_t       ctrl_i,
  input  trbf_pkg::word_t            x_i,
  output logic [trbf_pkg::RollW-1:0] roll_o
);
  import trbf_pkg::*;

  logic signed [AccW-1:0] px_full;
  word_t                  px_q;
  word_t                  oldest_q, middle_q, newest_q;
  logic signed [AccW-1:0] acc;
  word_t                  new_word;
  logic signed [SumW-1:0] tap_sum;
  logic signed [SumW-1:0] tap_rnd;
  logic signed [SumW-OutShift-1:0] roll_wide;
  logic [RollW-1:0]       roll_d, roll_q;

  assign px_full = coef_round(x_i, CoefB);

  // Feedback path: next delay word, saturated to 48 bits
  always_comb begin
    acc = coef_round(middle_q, CoefA0) + coef_round(newest_q, CoefA1)
        + AccW'(px_q);
    if (acc[AccW-1:WordW-1] == '0 || acc[AccW-1:WordW-1] == '1) begin
      new_word = acc[WordW-1:0];
    end else if (acc[AccW-1]) begin
      new_word = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      new_word = {1'b0, {(WordW-1){1'b1}}};
    end
  end

  // Output taps 1 2 1, round Q.32 to Q.8, saturate
  always_comb begin
    tap_sum   = SumW'(oldest_q) + SumW'(newest_q) + (SumW'(middle_q) <<< 1);
    tap_rnd   = tap_sum + (SumW'(1) <<< (OutShift - 1));
    roll_wide = tap_rnd[SumW-1:OutShift];
    if (roll_wide[SumW-OutShift-1:RollW-1] == '0 ||
        roll_wide[SumW-OutShift-1:RollW-1] == '1) begin
      roll_d = roll_wide[RollW-1:0];
    end else if (roll_wide[SumW-OutShift-1]) begin
      roll_d = {1'b1, {(RollW-1){1'b0}}};
    end else begin
      roll_d = {1'b0, {(RollW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      middle_q <= '0;
      newest_q <= '0;
    end else if (ctrl_i.load[4]) begin
      oldest_q <= middle_q;
      middle_q <= newest_q;
      newest_q <= new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      px_q <= px_full[WordW-1:0];
    end
    if (ctrl_i.load[5]) begin
      roll_q <= roll_d;
    end
  end

  assign roll_o = roll_q;

endmodule

`default_nettype wire

/* src/trbf_ctrl.sv */
// Stage valid flags and per-stage ready chain for the filter pipeline.
// Depends on trbf_pkg.
`default_nettype none

module trbf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output trbf_pkg::trbf_ctrl_t ctrl_o
);
  import trbf_pkg::*;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] feed;
  logic [NumStages:0]   ready;
  logic [NumStages-1:0] load;

  // A stage takes a beat when it is empty or its content moves on.
  always_comb begin
    ready[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    for (int k = 0; k < NumStages; k++) begin
      feed[k]    = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      load[k]    = ready[k] && feed[k];
      valid_d[k] = ready[k] ? feed[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load      = load;
  assign ctrl_o.in_ready  = ready[0];
  assign ctrl_o.out_valid = valid_q[NumStages-1];

endmodule

`default_nettype wire

/* src/trbf_checker.sv */
// Port-level checker for the tilt/roll filter, bound to the top level.
// Depends on trbf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module trbf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [trbf_pkg::RollW-1:0] m_axis_tdata
);
  import trbf_pkg::*;

  localparam int OccW = $clog2(NumStages + 1);

  logic [OccW-1:0] occ_d, occ_q;
  logic            in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Track samples in flight
  always_comb begin
    occ_d = occ_q + OccW'(in_beat) - OccW'(out_beat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `ASSERT_NEXT(out_hold_a, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPLY(no_phantom_a, clk_i, rst_ni, m_axis_tvalid, occ_q != '0)
  `ASSERT_IMPLY(occ_bound_a, clk_i, rst_ni, in_beat, occ_q < OccW'(NumStages) || out_beat)
  `ASSERT_IMPLY(ready_free_a, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind tilt_roll_butterworth_filter trbf_checker u_trbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the tilt/roll Butterworth filter: directed rows, then random phases
// with varied axis setup, idle and stall patterns, checked against an inline filter predictor.
// Depends on trbf_pkg and tilt_roll_butterworth_filter.
`timescale 1ns / 100ps

module testbench;
  import trbf_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Sample beat as it sits on s_axis_tdata: accel_x in the low bits
  typedef struct packed {
    logic [AccelW-1:0] accel_z;
    logic [AccelW-1:0] accel_y;
    logic [AccelW-1:0] accel_x;
  } sample_t;

  typedef enum logic {
    RowSample = 1'b0,
    RowWrite  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [AccelW-1:0]   ax;
    logic [AccelW-1:0]   ay;
    logic [AccelW-1:0]   az;
    bit                  fixed;
    logic [RollW-1:0]    roll;
  } step_t;

  // Axis code with no axis behind it, and register indexes with no register
  localparam logic [1:0] AxisNone = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  // Filter coefficients (Q1.30) and saturation bounds
  localparam wide_t KB      = 166589;
  localparam wide_t KA0     = -1036248020;
  localparam wide_t KA1     = 2109323487;
  localparam wide_t WordMax = (wide_t'(1) <<< 47) - 1;
  localparam wide_t WordMin = -(wide_t'(1) <<< 47);
  localparam wide_t RollMax = 8388607;
  localparam wide_t RollMin = -8388608;

  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 200;
  localparam int DrainCycles = 10;
  localparam int HoldCycles  = 80;
  localparam int CycleLimit  = 200000;
  localparam int NumDirected = 25;

  localparam logic [1:0] PhaseAxis [4] = '{AxisX, AxisY, AxisZ, AxisNone};

  // Directed rows. Right after reset the delay line is zero and the x axis is picked, so
  // the first rows (x held at zero) must give a zero roll regardless of y and z.
  localparam step_t DirectedRows [NumDirected] = '{
    '{RowSample, '0, '0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 24'h000000},
    '{RowSample, '0, '0, 16'h0000, 16'h7FFF, 16'h8000, 1'b1, 24'h000000},
    '{RowSample, '0, '0, 16'h0000, 16'h8000, 16'h7FFF, 1'b1, 24'h000000},
    '{RowSample, '0, '0, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, '0},
    '{RowSample, '0, '0, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0, '0},
    '{RowSample, '0, '0, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
    '{RowSample, '0, '0, 16'h8000, 16'h5555, 16'hAAAA, 1'b0, '0},
    '{RowSample, '0, '0, 16'hFFFF, 16'hAAAA, 16'h5555, 1'b0, '0},
    '{RowSample, '0, '0, 16'h0001, 16'h1234, 16'hFEDC, 1'b0, '0},
    '{RowWrite, CfgAxisSelect, AxisY, '0, '0, '0, 1'b0, '0},
    '{RowSample, '0, '0, 16'h1234, 16'h7FFF, 16'h0000, 1'b0, '0},
    '{RowSample, '0, '0, 16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
    '{RowWrite, CfgAxisSelect, AxisZ, '0, '0, '0, 1'b0, '0},
    '{RowSample, '0, '0, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, '0},
    '{RowSample, '0, '0, 16'h0000, 16'h0000, 16'h8000, 1'b0, '0},
    '{RowWrite, CfgInvertRoll, 2'd1, '0, '0, '0, 1'b0, '0},
    '{RowSample, '0, '0, 16'h0000, 16'h0000, 16'h8000, 1'b0, '0},
    '{RowSample, '0, '0, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, '0},
    '{RowWrite, CfgAxisSelect, AxisNone, '0, '0, '0, 1'b0, '0},
    '{RowSample, '0, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, '0},
    '{RowWrite, CfgSpareA, 2'd3, '0, '0, '0, 1'b0, '0},
    '{RowWrite, CfgSpareB, 2'd1, '0, '0, '0, 1'b0, '0},
    '{RowWrite, CfgInvertRoll, 2'd2, '0, '0, '0, 1'b0, '0},
    '{RowWrite, CfgAxisSelect, AxisX, '0, '0, '0, 1'b0, '0},
    '{RowSample, '0, '0, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // from bit 0: accel_x, accel_y, accel_z
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [RollW-1:0]    m_axis_tdata;   // from bit 0: roll_angle
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor state: configuration and the three delay words
  logic [1:0] roll_axis;
  logic       roll_invert;
  word_t      delay_old, delay_mid, delay_new;

  logic [RollW-1:0] roll_due[$];  // rolls still owed by the block, oldest first
  sample_t          walk_last;    // previous random sample, seeds the slow drift
  int               fault_count;
  int               idle_pct;
  int               stall_pct;
  int               hold_requests;

  tilt_roll_butterworth_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Round w*c/2^30 half up; arithmetic shift floors
  function automatic wide_t coef_product(input wide_t w, input wide_t c);
    return (w * c + (wide_t'(1) <<< 29)) >>> 30;
  endfunction

  function automatic wide_t clamp_wide(input wide_t v, input wide_t lo, input wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Register write as the block sees it: unused indexes drop, values mask to width
  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      CfgAxisSelect: roll_axis = val;
      CfgInvertRoll: roll_invert = val[0];
      default: ;
    endcase
  endfunction

  // Push one sample through the filter model and return the roll it produces
  function automatic logic [RollW-1:0] advance_filter(input sample_t s);
    wide_t sel, mag, x, fresh, total, r;
    case (roll_axis)
      AxisX:   sel = wide_t'(signed'(s.accel_x));
      AxisY:   sel = wide_t'(signed'(s.accel_y));
      AxisZ:   sel = wide_t'(signed'(s.accel_z));
      default: sel = 0;
    endcase
    if (roll_invert) sel = -sel;
    // scale by 450/49 into Q.32 degrees: round the magnitude, then restore the sign
    mag = (sel < 0) ? -sel : sel;
    mag = (mag * 450 * (wide_t'(1) <<< 24) + 24) / 49;
    x = (sel < 0) ? -mag : mag;
    fresh = coef_product(x, KB) + coef_product(wide_t'(delay_mid), KA0)
          + coef_product(wide_t'(delay_new), KA1);
    delay_old = delay_mid;
    delay_mid = delay_new;
    delay_new = word_t'(clamp_wide(fresh, WordMin, WordMax));
    total = wide_t'(delay_old) + wide_t'(delay_new) + 2 * wide_t'(delay_mid);
    r = clamp_wide((total + (wide_t'(1) <<< 23)) >>> 24, RollMin, RollMax);
    return r[RollW-1:0];
  endfunction

  // Mostly slow drift (filter settles on real tilts), some full-range noise, some corners
  function automatic logic [AccelW-1:0] next_axis(input logic [AccelW-1:0] prev);
    int pick, step, v;
    pick = $urandom_range(99);
    if (pick < 60) begin
      step = $urandom_range(512);
      v = int'(signed'(prev)) + step - 256;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[AccelW-1:0];
    end
    if (pick < 85) return AccelW'($urandom);
    case ($urandom_range(4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Offer one sample beat, with random idle cycles ahead of it, and book its roll
  task automatic offer_sample(input sample_t s, input bit fixed,
                              input logic [RollW-1:0] fixed_roll);
    bit taken;
    logic [RollW-1:0] roll;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    // sample the handshake mid-cycle, where every signal has settled
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    roll = advance_filter(s);
    roll_due.push_back(fixed ? fixed_roll : roll);
  endtask

  // Hold the input until every booked roll has come out, then let the pipe settle
  task automatic await_drain();
    s_axis_tvalid <= 1'b0;
    while (roll_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  initial begin : roll_sink
    int served, hold_left;
    served = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each output beat with the oldest booked roll
  always @(negedge clk_i) begin
    logic [RollW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (roll_due.size() == 0) begin
        $error("roll_angle: no beat expected, got %0d", $signed(m_axis_tdata));
        fault_count++;
      end else begin
        want = roll_due.pop_front();
        if (want !== m_axis_tdata) begin
          $error("roll_angle: expected %0d, got %0d", $signed(want), $signed(m_axis_tdata));
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : cycle_guard
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    step_t   row;
    sample_t s;
    bit      inv;
    fault_count   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    roll_axis     = AxisX;
    roll_invert   = 1'b0;
    delay_old     = '0;
    delay_mid     = '0;
    delay_new     = '0;
    walk_last     = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at full rate; register writes wait for the pipe to empty
    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      if (row.kind == RowWrite) begin
        await_drain();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_sample({row.az, row.ay, row.ax}, row.fixed, row.roll);
      end
    end

    // Random phases: each axis code twice, both invert settings, four idle patterns
    for (int p = 0; p < NumPhases; p++) begin
      await_drain();
      case ((p / 2) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      inv = p[1] ^ p[2];
      write_reg(CfgAxisSelect, PhaseAxis[p % 4]);
      write_reg(CfgInvertRoll, {1'b0, inv});
      if (p == 3) write_reg(CfgSpareA, CfgDataW'($urandom));
      for (int n = 0; n < PhaseItems; n++) begin
        // starve the output so the pipe fills and backs up into the input
        if (n == 60 && (p == 0 || p == 5)) hold_requests++;
        // let the block run dry mid-phase
        if (n == 120 && (p == 3 || p == 6)) await_drain();
        s.accel_x = next_axis(walk_last.accel_x);
        s.accel_y = next_axis(walk_last.accel_y);
        s.accel_z = next_axis(walk_last.accel_z);
        walk_last = s;
        offer_sample(s, 1'b0, '0);
      end
    end

    await_drain();
    if (fault_count == 0 && roll_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
